@@ hdl/disparity_to_depth_converter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the disparity to depth converter
// Implication checks, sampled on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_TO_DEPTH_CONVERTER_ASSERT_SVH
`define DISPARITY_TO_DEPTH_CONVERTER_ASSERT_SVH

// same-cycle implication
`define D2D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("d2d assertion failed");

// next-cycle implication
`define D2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("d2d assertion failed");

`endif

@@ hdl/d2d_pkg.sv @@
// ----------------------------------------------------------------------------
// d2d_pkg
// Widths, register indexes and shared types of the disparity to depth converter.
// ----------------------------------------------------------------------------
`default_nettype none

package d2d_pkg;

    localparam int DISP_W  = 16;
    localparam int Z0_W    = 14;
    localparam int PIX_W   = 20;
    localparam int BASE_W  = 20;
    localparam int COEF_W  = 7;
    localparam int OFF_W   = 12;
    localparam int SCALE_W = 5;
    localparam int DEPTH_W = 16;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 20;

    localparam logic [Z0_W-1:0]    RST_Z0    = 14'd1300;
    localparam logic [PIX_W-1:0]   RST_PIX   = 20'd73446;
    localparam logic [BASE_W-1:0]  RST_BASE  = 20'd15360;
    localparam logic [COEF_W-1:0]  RST_COEF  = 7'd8;
    localparam logic [OFF_W-1:0]   RST_OFF   = 12'd200;
    localparam logic [SCALE_W-1:0] RST_SCALE = 5'd1;
    localparam logic [DEPTH_W-1:0] RST_MIN   = 16'd0;
    localparam logic [DEPTH_W-1:0] RST_MAX   = 16'd8000;

    typedef enum logic [IDX_W-1:0] {
        REG_Z0    = 4'd0,
        REG_PIX   = 4'd1,
        REG_BASE  = 4'd2,
        REG_COEF  = 4'd3,
        REG_OFF   = 4'd4,
        REG_SCALE = 4'd5,
        REG_MIN   = 4'd6,
        REG_MAX   = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic bad;
        logic eof;
        logic nsign;
        logic dsign;
        logic dneg;
        logic dzero;
        logic ovf;
    } t_side;

endpackage

`default_nettype wire

@@ hdl/d2d_if.sv @@
// ----------------------------------------------------------------------------
// d2d_if
// Valid/ready channels: pixel requests, depth results, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface d2d_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] disparity;
    logic        end_of_frame;
    modport source (output valid, disparity, end_of_frame, input ready);
    modport sink   (input valid, disparity, end_of_frame, output ready);
endinterface

interface d2d_depth_if;
    logic        valid;
    logic        ready;
    logic [15:0] depth;
    logic        rejected;
    logic        frame_last;
    modport source (output valid, depth, rejected, frame_last, input ready);
    modport sink   (input valid, depth, rejected, frame_last, output ready);
endinterface

interface d2d_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [19:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/disparity_to_depth_converter.sv @@
// ----------------------------------------------------------------------------
// disparity_to_depth_converter
// Per-pixel structured-light disparity to depth, Q16 fixed point, 32 stages.
// ----------------------------------------------------------------------------
//  port     dir   request         payload
//  i_pix    in    one pixel       disparity, end_of_frame
//  o_depth  out   one depth       depth, rejected, frame_last
//  i_cfg    in    register write  index, data
//
//  One pixel per clock while the output is not stalled. The pipeline holds
//  the offset divider (6 stages, 6 bits each) and the depth divider (16 stages,
//  2 bits each). Synchronous reset clears valids and loads register defaults.
//  Each stage has its own enable, so bubbles close up under an output stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "disparity_to_depth_converter_assert.svh"

module disparity_to_depth_converter
    import d2d_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    d2d_pix_if.sink        i_pix,
    d2d_depth_if.source    o_depth,
    d2d_cfg_if.sink        i_cfg
);

    localparam int NMAG_W = 19;
    localparam int D1_W   = 36;
    localparam int D1_SPS = 6;
    localparam int D1_NST = 6;
    localparam int D_W    = 38;
    localparam int DMAG_W = 36;
    localparam int HALF_W = 18;
    localparam int PP_W   = HALF_W + PIX_W;
    localparam int SUM_W  = 56;
    localparam int MM_W   = SUM_W - 16;
    localparam int DEN_W  = 42;
    localparam int DV_W   = DEN_W - 1;
    localparam int ZB_W   = Z0_W + BASE_W;
    localparam int Q2_W   = 32;
    localparam int D2_SPS = 2;
    localparam int D2_NST = Q2_W / D2_SPS;
    localparam int PROD_W = SCALE_W + Q2_W;

    localparam int ST_S1  = 0;
    localparam int ST_D1  = 1;
    localparam int ST_M0  = ST_D1 + D1_NST;
    localparam int ST_M1  = ST_M0 + 1;
    localparam int ST_M2  = ST_M1 + 1;
    localparam int ST_M3  = ST_M2 + 1;
    localparam int ST_M4  = ST_M3 + 1;
    localparam int ST_M5  = ST_M4 + 1;
    localparam int ST_M6  = ST_M5 + 1;
    localparam int ST_D2  = ST_M6 + 1;
    localparam int ST_F0  = ST_D2 + D2_NST;
    localparam int ST_OUT = ST_F0 + 1;
    localparam int NST    = ST_OUT + 1;

    // configuration
    logic [Z0_W-1:0]    r_z0;
    logic [PIX_W-1:0]   r_pix;
    logic [BASE_W-1:0]  r_base;
    logic [COEF_W-1:0]  r_coeff;
    logic [OFF_W-1:0]   r_off;
    logic [SCALE_W-1:0] r_scale;
    logic [DEPTH_W-1:0] r_min;
    logic [DEPTH_W-1:0] r_max;
    logic [ZB_W-1:0]    r_zb;

    // pipeline
    logic [NST-1:0]     r_v;
    logic [NST-1:0]     stg_en;
    t_side              r_side [NST];
    t_side              n_side [NST];

    logic [DISP_W+4:0]  s1_num;
    logic [NMAG_W-1:0]  r_s1_nmag, n_s1_nmag;
    logic [COEF_W-1:0]  r_d1_rem [D1_NST];
    logic [COEF_W-1:0]  n_d1_rem [D1_NST];
    logic [D1_W-1:0]    r_d1_qd  [D1_NST];
    logic [D1_W-1:0]    n_d1_qd  [D1_NST];
    logic [D_W-1:0]     r_m0_d, n_m0_d;
    logic [DMAG_W-1:0]  r_m1_dmag, n_m1_dmag;
    logic [PP_W-1:0]    r_pp_lo, r_pp_hi, n_pp_lo, n_pp_hi;
    logic [MM_W-1:0]    r_mm, n_mm;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [DV_W-1:0]    r_dv, n_dv, r_m6_dv;
    logic [DV_W-1:0]    r_d2_rem [D2_NST];
    logic [DV_W-1:0]    n_d2_rem [D2_NST];
    logic [Q2_W-1:0]    r_d2_qd  [D2_NST];
    logic [Q2_W-1:0]    n_d2_qd  [D2_NST];
    logic [DV_W-1:0]    r_d2_dv  [D2_NST];
    logic               r_f0_rej, n_f0_rej;
    logic [PROD_W-1:0]  r_f0_prod, n_f0_prod;
    logic [DEPTH_W-1:0] r_o_depth, n_o_depth;
    logic               r_o_rej;
    logic               r_o_eof;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z0    <= RST_Z0;
            r_pix   <= RST_PIX;
            r_base  <= RST_BASE;
            r_coeff <= RST_COEF;
            r_off   <= RST_OFF;
            r_scale <= RST_SCALE;
            r_min   <= RST_MIN;
            r_max   <= RST_MAX;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_Z0:    r_z0    <= i_cfg.data[Z0_W-1:0];
                REG_PIX:   r_pix   <= i_cfg.data[PIX_W-1:0];
                REG_BASE:  r_base  <= i_cfg.data[BASE_W-1:0];
                REG_COEF:  r_coeff <= i_cfg.data[COEF_W-1:0];
                REG_OFF:   r_off   <= i_cfg.data[OFF_W-1:0];
                REG_SCALE: r_scale <= i_cfg.data[SCALE_W-1:0];
                REG_MIN:   r_min   <= i_cfg.data[DEPTH_W-1:0];
                REG_MAX:   r_max   <= i_cfg.data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // z0 * baseline, static between writes
    always_ff @(posedge i_clk) begin
        r_zb <= r_z0 * r_base;
    end

    // stage enables, back to front
    always_comb begin
        stg_en[NST-1] = !r_v[NST-1] || o_depth.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            stg_en[k] = !r_v[k] || stg_en[k+1];
        end
    end

    assign i_pix.ready = stg_en[ST_S1];

    // disparity minus coeff * offset
    assign s1_num = {5'b0, i_pix.disparity} -
                    {2'b0, NMAG_W'(r_coeff) * NMAG_W'(r_off)};

    // sideband
    always_comb begin
        logic signed [D_W-1:0] d;
        logic signed [DEN_W-1:0] den;
        d   = $signed(r_m0_d);
        den = $signed(r_den);
        n_side[0]       = '0;
        n_side[0].bad   = (i_pix.disparity == '0) || (r_coeff == '0);
        n_side[0].eof   = i_pix.end_of_frame;
        n_side[0].nsign = s1_num[DISP_W+4];
        for (int k = 1; k < NST; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[ST_M1].dsign = d[D_W-1];
        n_side[ST_M5].dneg  = den[DEN_W-1];
        n_side[ST_M5].dzero = (r_den == '0);
        n_side[ST_M6].ovf   = {{(DV_W+8-ZB_W){1'b0}}, r_zb} >= {r_dv, 8'b0};
    end

    // S1: offset removal and magnitude
    always_comb begin
        n_s1_nmag = s1_num[DISP_W+4] ? NMAG_W'(-s1_num) : s1_num[NMAG_W-1:0];
    end

    // D1: |num| * 2^16 / coeff, restoring
    always_comb begin
        logic [COEF_W-1:0] rem;
        logic [COEF_W:0]   t;
        logic [D1_W-1:0]   qd;
        for (int j = 0; j < D1_NST; j++) begin
            if (j == 0) begin
                rem = '0;
                qd  = {1'b0, r_s1_nmag, 16'b0};
            end else begin
                rem = r_d1_rem[j-1];
                qd  = r_d1_qd[j-1];
            end
            for (int i = 0; i < D1_SPS; i++) begin
                t  = {rem, qd[D1_W-1]};
                qd = {qd[D1_W-2:0], 1'b0};
                if (t >= {1'b0, r_coeff}) begin
                    t     = t - {1'b0, r_coeff};
                    qd[0] = 1'b1;
                end
                rem = t[COEF_W-1:0];
            end
            n_d1_rem[j] = rem;
            n_d1_qd[j]  = qd;
        end
    end

    // M0..M5: real disparity, metric, denominator
    always_comb begin
        logic [D_W-1:0]   sv;
        logic [SUM_W-1:0] sum;
        logic [DEN_W-1:0] b256;
        sv = {2'b0, r_d1_qd[D1_NST-1]};
        if (r_side[ST_M0-1].nsign) begin
            sv = -sv;
        end
        n_m0_d    = sv - D_W'(24576);
        n_m1_dmag = r_m0_d[D_W-1] ? DMAG_W'(-r_m0_d) : r_m0_d[DMAG_W-1:0];
        n_pp_lo   = r_m1_dmag[HALF_W-1:0] * r_pix;
        n_pp_hi   = r_m1_dmag[DMAG_W-1:HALF_W] * r_pix;
        sum       = {{(SUM_W-PP_W){1'b0}}, r_pp_lo} + {r_pp_hi, {HALF_W{1'b0}}};
        n_mm      = sum[SUM_W-1:16];
        b256      = {{(DEN_W-BASE_W-8){1'b0}}, r_base, 8'b0};
        n_den     = r_side[ST_M4-1].dsign ? b256 + {2'b0, r_mm} : b256 - {2'b0, r_mm};
        n_dv      = r_den[DEN_W-1] ? DV_W'(-r_den) : r_den[DV_W-1:0];
    end

    // D2: z0*b*2^24 / |den|, low 32 quotient bits
    always_comb begin
        logic [DV_W-1:0] rem;
        logic [DV_W:0]   t;
        logic [Q2_W-1:0] qd;
        logic [DV_W-1:0] dv;
        for (int j = 0; j < D2_NST; j++) begin
            if (j == 0) begin
                rem = {{(DV_W-ZB_W+8){1'b0}}, r_zb[ZB_W-1:8]};
                qd  = {r_zb[7:0], 24'b0};
                dv  = r_m6_dv;
            end else begin
                rem = r_d2_rem[j-1];
                qd  = r_d2_qd[j-1];
                dv  = r_d2_dv[j-1];
            end
            for (int i = 0; i < D2_SPS; i++) begin
                t  = {rem, qd[Q2_W-1]};
                qd = {qd[Q2_W-2:0], 1'b0};
                if (t >= {1'b0, dv}) begin
                    t     = t - {1'b0, dv};
                    qd[0] = 1'b1;
                end
                rem = t[DV_W-1:0];
            end
            n_d2_rem[j] = rem;
            n_d2_qd[j]  = qd;
        end
    end

    // F0 range check and unit scale, OUT saturation
    always_comb begin
        logic [Q2_W-1:0] q;
        t_side           sd;
        q  = r_d2_qd[D2_NST-1];
        sd = r_side[ST_F0-1];
        n_f0_rej  = sd.bad || sd.dzero || sd.ovf || (sd.dneg && (q != '0)) ||
                    (q < {r_min, 16'b0}) || (q > {r_max, 16'b0});
        n_f0_prod = r_scale * q;
        if (r_f0_rej) begin
            n_o_depth = '0;
        end else if (r_f0_prod[PROD_W-1:32] != '0) begin
            n_o_depth = '1;
        end else begin
            n_o_depth = r_f0_prod[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stg_en[0]) begin
                r_v[0] <= i_pix.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (stg_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (stg_en[k]) begin
                r_side[k] <= n_side[k];
            end
        end
        if (stg_en[ST_S1]) r_s1_nmag <= n_s1_nmag;
        for (int j = 0; j < D1_NST; j++) begin
            if (stg_en[ST_D1+j]) begin
                r_d1_rem[j] <= n_d1_rem[j];
                r_d1_qd[j]  <= n_d1_qd[j];
            end
        end
        if (stg_en[ST_M0]) r_m0_d    <= n_m0_d;
        if (stg_en[ST_M1]) r_m1_dmag <= n_m1_dmag;
        if (stg_en[ST_M2]) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
        end
        if (stg_en[ST_M3]) r_mm    <= n_mm;
        if (stg_en[ST_M4]) r_den   <= n_den;
        if (stg_en[ST_M5]) r_dv    <= n_dv;
        if (stg_en[ST_M6]) r_m6_dv <= r_dv;
        if (stg_en[ST_D2]) r_d2_dv[0] <= r_m6_dv;
        for (int j = 1; j < D2_NST; j++) begin
            if (stg_en[ST_D2+j]) begin
                r_d2_dv[j] <= r_d2_dv[j-1];
            end
        end
        for (int j = 0; j < D2_NST; j++) begin
            if (stg_en[ST_D2+j]) begin
                r_d2_rem[j] <= n_d2_rem[j];
                r_d2_qd[j]  <= n_d2_qd[j];
            end
        end
        if (stg_en[ST_F0]) begin
            r_f0_rej  <= n_f0_rej;
            r_f0_prod <= n_f0_prod;
        end
        if (stg_en[ST_OUT]) begin
            r_o_depth <= n_o_depth;
            r_o_rej   <= r_f0_rej;
            r_o_eof   <= r_side[ST_F0].eof;
        end
    end

    assign o_depth.valid      = r_v[ST_OUT];
    assign o_depth.depth      = r_o_depth;
    assign o_depth.rejected   = r_o_rej;
    assign o_depth.frame_last = r_o_eof;

    `D2D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_v[ST_OUT] && !o_depth.ready, r_v[ST_OUT] && $stable(r_o_depth))
    `D2D_ASSERT_NEXT(a_rej_zero, i_clk, i_rst_n, stg_en[ST_OUT] && r_v[ST_F0] && r_f0_rej, r_o_rej && (r_o_depth == '0))
    `D2D_ASSERT_NEXT(a_bad_rej, i_clk, i_rst_n, stg_en[ST_F0] && r_v[ST_F0-1] && r_side[ST_F0-1].bad, r_f0_rej)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the disparity to depth converter. Pixel requests
// are queued by the stimulus process and sent by a clocked driver. A Q16
// depth predictor turns every accepted pixel into an expected depth, and
// the monitor checks each returned depth against the oldest one waiting.
// Register settings change between phases, with both sides stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import d2d_pkg::*;

    localparam logic [IDX_W-1:0] IDX_UNUSED = 4'd15;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [15:0] disparity;
        logic        end_of_frame;
    } t_pixel;

    typedef struct packed {
        logic [15:0] depth;
        logic        rejected;
        logic        frame_last;
    } t_depth;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    d2d_pix_if   pix_if();
    d2d_depth_if depth_if();
    d2d_cfg_if   cfg_if();

    disparity_to_depth_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if.sink),
        .o_depth (depth_if.source),
        .i_cfg   (cfg_if.sink)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        pix_if.valid        = 1'b0;
        pix_if.disparity    = '0;
        pix_if.end_of_frame = 1'b0;
        depth_if.ready      = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
    end

    t_pixel pixel_q[$];
    t_depth depth_q[$];
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     errors = 0;
    logic   hold_go = 1'b0;
    int     hold_cnt = 0;

    logic [Z0_W-1:0]    cf_z0;
    logic [PIX_W-1:0]   cf_pix;
    logic [BASE_W-1:0]  cf_base;
    logic [COEF_W-1:0]  cf_coef;
    logic [OFF_W-1:0]   cf_off;
    logic [SCALE_W-1:0] cf_scale;
    logic [DEPTH_W-1:0] cf_min;
    logic [DEPTH_W-1:0] cf_max;

    function automatic t_depth convert_pixel(logic [15:0] s, logic eof);
        t_depth r;
        longint num, d16, m16, den16, numer, dep16, scaled;
        r.frame_last = eof;
        r.depth      = '0;
        r.rejected   = 1'b1;
        if (s == 0 || cf_coef == 0) return r;
        num   = longint'(s) - longint'(cf_coef) * longint'(cf_off);
        d16   = (num * 65536) / longint'(cf_coef) - 24576;
        m16   = (d16 * longint'(cf_pix)) / 65536;
        den16 = longint'(cf_base) * 256 - m16;
        if (den16 == 0) return r;
        numer = longint'(cf_z0) * longint'(cf_base) * 256 * 65536;
        dep16 = numer / den16;
        if (dep16 < longint'(cf_min) * 65536 || dep16 > longint'(cf_max) * 65536)
            return r;
        scaled = (longint'(cf_scale) * dep16) / 65536;
        if (scaled > 65535) scaled = 65535;
        r.depth    = scaled[15:0];
        r.rejected = 1'b0;
        return r;
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_if.ready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_pixel p;
                p = pixel_q.pop_front();
                pix_if.valid        <= 1'b1;
                pix_if.disparity    <= p.disparity;
                pix_if.end_of_frame <= p.end_of_frame;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // long output stall
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_cnt <= 400;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_if.ready <= 1'b0;
        end else begin
            depth_if.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // register shadow, predictor and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cf_z0    <= RST_Z0;
            cf_pix   <= RST_PIX;
            cf_base  <= RST_BASE;
            cf_coef  <= RST_COEF;
            cf_off   <= RST_OFF;
            cf_scale <= RST_SCALE;
            cf_min   <= RST_MIN;
            cf_max   <= RST_MAX;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_Z0:    cf_z0    <= cfg_if.data[Z0_W-1:0];
                    REG_PIX:   cf_pix   <= cfg_if.data[PIX_W-1:0];
                    REG_BASE:  cf_base  <= cfg_if.data[BASE_W-1:0];
                    REG_COEF:  cf_coef  <= cfg_if.data[COEF_W-1:0];
                    REG_OFF:   cf_off   <= cfg_if.data[OFF_W-1:0];
                    REG_SCALE: cf_scale <= cfg_if.data[SCALE_W-1:0];
                    REG_MIN:   cf_min   <= cfg_if.data[DEPTH_W-1:0];
                    REG_MAX:   cf_max   <= cfg_if.data[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            if (pix_if.valid && pix_if.ready)
                depth_q.push_back(convert_pixel(pix_if.disparity, pix_if.end_of_frame));
            if (depth_if.valid && depth_if.ready) begin
                if (depth_q.size() == 0) begin
                    $error("unexpected depth result %0d", depth_if.depth);
                    errors++;
                end else begin
                    t_depth e;
                    e = depth_q.pop_front();
                    if (depth_if.depth !== e.depth) begin
                        $error("depth: expected %0d, got %0d", e.depth, depth_if.depth);
                        errors++;
                    end
                    if (depth_if.rejected !== e.rejected) begin
                        $error("rejected: expected %0b, got %0b", e.rejected,
                               depth_if.rejected);
                        errors++;
                    end
                    if (depth_if.frame_last !== e.frame_last) begin
                        $error("frame_last: expected %0b, got %0b", e.frame_last,
                               depth_if.frame_last);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_regs(int z0, int pix, int base, int coef, int off, int scale,
                             int mn, int mx);
        write_reg(REG_Z0, DATA_W'(z0));
        write_reg(REG_PIX, DATA_W'(pix));
        write_reg(REG_BASE, DATA_W'(base));
        write_reg(REG_COEF, DATA_W'(coef));
        write_reg(REG_OFF, DATA_W'(off));
        write_reg(REG_SCALE, DATA_W'(scale));
        write_reg(REG_MIN, DATA_W'(mn));
        write_reg(REG_MAX, DATA_W'(mx));
    endtask

    task automatic push_pixel(int s, bit eof);
        t_pixel p;
        p.disparity    = s[15:0];
        p.end_of_frame = eof;
        pixel_q.push_back(p);
    endtask

    // checked between edges so that queue pops and valid updates have settled
    task automatic drain();
        while (pixel_q.size() != 0 || pix_if.valid || depth_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random pixels, mostly near the offset point so depths land in range
    task automatic push_random(int n);
        int c;
        int s;
        c = cf_coef * cf_off;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0 || c > 60000)
                s = $urandom_range(65535);
            else
                s = c + $urandom_range(0, 80 * (cf_coef + 1));
            if (s > 65535) s = $urandom_range(65535);
            push_pixel(s, $urandom_range(15) == 0);
        end
    endtask

    initial begin
        int dir[$];
        dir = '{0, 1, 65535, 1600, 1601, 1603, 1620, 1700, 1900, 2400, 3200, 6000,
                32768, 40000, 1599, 1000, 255};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero, extremes, around the offset point, far range
        foreach (dir[i]) push_pixel(dir[i], i[0]);
        drain();

        // coefficient of zero rejects everything; unused index is ignored
        write_reg(REG_COEF, DATA_W'(0));
        write_reg(IDX_UNUSED, 20'hFFFFF);
        for (int i = 0; i < 5; i++) push_pixel(1600 + 50 * i, i == 4);
        drain();

        // zero output scale
        write_reg(REG_COEF, DATA_W'(8));
        write_reg(REG_SCALE, DATA_W'(0));
        for (int i = 0; i < 5; i++) push_pixel(1610 + 40 * i, 1'b0);
        drain();

        // zero denominator: base*256 == m16 at s = 1 with pix = 1<<16, coeff 1, off 0
        load_regs(1300, 65536, 160, 1, 0, 16, 0, 65535);
        push_pixel(1, 1'b0);
        push_pixel(2, 1'b1);
        push_pixel(3, 1'b0);
        push_pixel(65535, 1'b1);
        drain();

        // highest values, saturation
        load_regs(16383, 1048575, 1048575, 127, 4095, 31, 65535, 65535);
        push_random(12);
        drain();
        load_regs(16383, 0, 1048575, 64, 0, 31, 0, 65535);
        push_pixel(1, 1'b0);
        push_pixel(65535, 1'b1);
        drain();

        // lowest values
        load_regs(1, 0, 1, 1, 0, 1, 0, 0);
        push_random(10);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            load_regs($urandom_range(200, 5000), $urandom_range(20000, 200000),
                      $urandom_range(2000, 40000), $urandom_range(1, 64),
                      $urandom_range(0, 1500), $urandom_range(1, 16),
                      $urandom_range(0, 1000), $urandom_range(2000, 65535));
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 47 : 0;
            recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 9 : 0;
            push_random(400);
            if (ph == 3) begin
                repeat (20) @(posedge i_clk);
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            drain();
        end

        if (errors == 0 && depth_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/d2d_pkg.sv
hdl/d2d_if.sv
hdl/disparity_to_depth_converter.sv
tb/tb_top.sv
